// ----- sv/fdm_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths and low-pass filter coefficient tables for the FSK
// delay-multiply demodulator. No dependencies.
package fdm_pkg;

   // Field and datapath widths.
   localparam int SAMPLE_W = 12;
   localparam int MULT_W   = 2 * SAMPLE_W;
   localparam int SHIFT    = 12;
   localparam int PROD_W   = 12;
   localparam int COEF_W   = 16;
   localparam int ACC_W    = 28;
   localparam int MAX_TAPS = 15;

   typedef logic signed [COEF_W-1:0] coef_type;

   // Q16 low-pass coefficients. The 11-tap set is padded with zeros so that
   // both tables index alike.
   localparam coef_type COEF11_TAB [MAX_TAPS] = '{
      -16'sd2618, -16'sd5080, -16'sd1527, 16'sd8168, 16'sd18786, 16'sd23385,
      16'sd18786, 16'sd8168, -16'sd1527, -16'sd5080, -16'sd2618,
      16'sd0, 16'sd0, 16'sd0, 16'sd0
   };

   localparam coef_type COEF15_TAB [MAX_TAPS] = '{
      -16'sd2252, -16'sd980, 16'sd1175, 16'sd3941, 16'sd6883, 16'sd9488,
      16'sd11278, 16'sd11916, 16'sd11278, 16'sd9488, 16'sd6883, 16'sd3941,
      16'sd1175, -16'sd980, -16'sd2252
   };

endpackage

// ----- sv/fdm_delay_cell.sv -----
`timescale 1ns / 1ps
// One stage of the sample delay line: holds one earlier sample and hands it
// on to its neighbor when a new item arrives. Uses fdm_pkg.
module fdm_delay_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 shift_en,
   input  logic signed [fdm_pkg::SAMPLE_W-1:0]  sample_in,
   output logic signed [fdm_pkg::SAMPLE_W-1:0]  sample_ff
);

   logic signed [fdm_pkg::SAMPLE_W-1:0] stage_in;

   // Take the neighbor's sample on each accepted item.
   always_comb begin
      stage_in = shift_en ? sample_in : sample_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else begin
         sample_ff <= stage_in;
      end
   end

endmodule

// ----- sv/fdm_fir_cell.sv -----
`timescale 1ns / 1ps
// One cell of the transposed low-pass filter: multiplies the newest product
// by its fixed coefficient and adds the partial sum from its right neighbor.
// Uses fdm_pkg.
module fdm_fir_cell #(
   parameter fdm_pkg::coef_type COEF = 16'sd0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step_en,
   input  logic signed [fdm_pkg::PROD_W-1:0]  prod,
   input  logic signed [fdm_pkg::ACC_W-1:0]   acc_prev,
   output logic signed [fdm_pkg::ACC_W-1:0]   acc_ff
);

   logic signed [fdm_pkg::ACC_W-1:0] weighted;
   logic signed [fdm_pkg::ACC_W-1:0] acc_in;

   // Weighted product plus the neighbor's partial sum.
   always_comb begin
      weighted = fdm_pkg::ACC_W'(COEF) * fdm_pkg::ACC_W'(prod);
      acc_in   = step_en ? (weighted + acc_prev) : acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

// ----- sv/fsk_delay_multiply_demod.sv -----
`timescale 1ns / 1ps
// FSK delay-multiply demodulator front end. Each sample is multiplied by the
// sample DELAY items earlier, shifted right by 12 and passed through a fixed
// low-pass filter (11 or 15 taps, chosen by TAPS); the sign of each result
// tells mark from space. The block takes one item per cycle while results are
// taken; each accepted sample is registered first in the product register by
// the delay-line multiply, then in the row of filter cells whose first cell is
// the output register. A result that is not taken stalls both stages, and
// the input then waits. Depends on fdm_pkg, fdm_delay_cell and fdm_fir_cell.
module fsk_delay_multiply_demod #(
   parameter int DELAY = 6,
   parameter int TAPS  = 11
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [fdm_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [fdm_pkg::ACC_W-1:0]     rsp_filtered_product
);

   localparam bit USE15    = (TAPS == 15);
   localparam int NUM_TAPS = USE15 ? 15 : 11;

   logic                                advance;
   logic                                req_accept;
   logic signed [fdm_pkg::SAMPLE_W-1:0] dly_tap [DELAY+1];
   logic signed [fdm_pkg::MULT_W-1:0]   mult;
   logic signed [fdm_pkg::PROD_W-1:0]   prod_ff;
   logic signed [fdm_pkg::PROD_W-1:0]   prod_in;
   logic                                prod_valid_ff;
   logic                                prod_valid_in;
   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic                                fir_step;
   logic signed [fdm_pkg::ACC_W-1:0]    acc_tap [NUM_TAPS+1];

   // Both stages move together whenever the output slot is free or drains.
   assign advance    = !rsp_valid_ff || rsp_ready;
   assign req_ready  = advance;
   assign req_accept = req_valid && advance;
   assign fir_step   = advance && prod_valid_ff;

   // Sample delay line.
   assign dly_tap[0] = req_sample;
   for (genvar k = 0; k < DELAY; k++) begin : g_delay
      fdm_delay_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (req_accept),
         .sample_in (dly_tap[k]),
         .sample_ff (dly_tap[k+1])
      );
   end

   // Delay-multiply, floored shift by 12.
   always_comb begin
      mult          = fdm_pkg::MULT_W'(req_sample) * fdm_pkg::MULT_W'(dly_tap[DELAY]);
      prod_in       = req_accept ? mult[fdm_pkg::SHIFT +: fdm_pkg::PROD_W] : prod_ff;
      prod_valid_in = advance ? req_accept : prod_valid_ff;
      rsp_valid_in  = advance ? prod_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Transposed filter: cell 0 holds the finished result.
   assign acc_tap[NUM_TAPS] = '0;
   for (genvar k = 0; k < NUM_TAPS; k++) begin : g_fir
      localparam fdm_pkg::coef_type COEF_K =
         USE15 ? fdm_pkg::COEF15_TAB[k] : fdm_pkg::COEF11_TAB[k];
      fdm_fir_cell #(
         .COEF (COEF_K)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .step_en  (fir_step),
         .prod     (prod_ff),
         .acc_prev (acc_tap[k+1]),
         .acc_ff   (acc_tap[k])
      );
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_filtered_product = acc_tap[0];

endmodule
